// ===== hdl/bcgd_pkg.sv =====
package bcgd_pkg;

  localparam int unsigned MaxButtons  = 4;
  // Button slots addressed by the 2-bit button field
  localparam int unsigned ButtonSlots = 4;
  localparam int unsigned NumCells    = (MaxButtons < ButtonSlots) ? MaxButtons : ButtonSlots;

  localparam int unsigned DelayW = 16;
  localparam int unsigned ClickW = 8;
  localparam int unsigned CountW = 3;
  localparam int unsigned IdxW   = 2;

  localparam logic [ClickW-1:0] ClickReset = {ClickW{1'b1}};
  localparam logic [DelayW-1:0] DelayMax   = {DelayW{1'b1}};

  typedef enum logic [3:0] {
    G_NONE     = 4'd0,
    G_SINGLE   = 4'd1,
    G_DOUBLE   = 4'd2,
    G_TRIPLE   = 4'd3,
    G_LONG     = 4'd4,
    G_DLONG    = 4'd5,
    G_TLONG    = 4'd6,
    G_VLONG    = 4'd7,
    G_RELEASED = 4'd8
  } gesture_e;

  typedef enum logic [2:0] {
    REG_NUM_BUTTONS = 3'd0,
    REG_TICK_STEP   = 3'd1,
    REG_EDGE_STEP   = 3'd2,
    REG_SINGLE_LIM  = 3'd3,
    REG_DOUBLE_LIM  = 3'd4,
    REG_VLONG_LIM   = 3'd5,
    REG_ACTIVE_HIGH = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR_G,
    OP_ADD,
    OP_EDGE,
    OP_TICK,
    OP_STOP
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CLASS,
    S_STOP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [DelayW-1:0] edge_step;
    logic [DelayW-1:0] single_lim;
    logic [DelayW-1:0] double_lim;
    logic [DelayW-1:0] vlong_lim;
  } lim_t;

  typedef struct packed {
    cell_op_e          op;
    logic [DelayW-1:0] step;
    logic              rel;
    logic              stop;
  } cell_ctrl_t;

endpackage

// ===== hdl/button_click_gesture_detector.sv =====
// Gesture detector for up to four buttons. Each button lives in one cell of a chain holding
// its hold delay, click count and last reported gesture; the cells pass a keep-running flag
// along the row so the tick timer stops once every button is released and out of its click
// window. One item at a time: an edge item passes through accept, delay add, classify and
// output to its single result; an active tick item adds a stop check after the classify,
// then gives one result per output transaction for each button in use (one when none is
// in use); an edge on an unused button or a tick with the timer stopped goes from accept
// straight to the output. The saturating add and the classify compare are separate states,
// and the output stage steps through the cells' registered gestures.
module button_click_gesture_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] cmd, [2:1] button_index, [3] is_release, [7:4] pin_levels
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] out_button, [5:2] gesture, [6] timer_running, [7] zero
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bcgd_pkg::*;

  state_e                   state_q, state_d;
  logic [CountW-1:0]        num_q;
  logic [DelayW-1:0]        tick_step_q, edge_step_q, single_lim_q, double_lim_q, vlong_lim_q;
  logic                     active_high_q;
  logic                     cmd_q, rel_q;
  logic [IdxW-1:0]          idx_q;
  logic [ButtonSlots-1:0]   pins_q;
  logic [IdxW-1:0]          btn_q, btn_d;
  logic                     timer_q, timer_d;

  logic                     in_acc, out_acc;
  logic [CountW-1:0]        n_eff;
  logic                     edge_ok, stop, last;
  cell_ctrl_t               ctrl;
  lim_t                     lim;
  logic [ButtonSlots-1:0]   en;
  logic [ButtonSlots:0]     busy;
  gesture_e                 g_slot [ButtonSlots];

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;
  assign n_eff   = (num_q > CountW'(NumCells)) ? CountW'(NumCells) : num_q;
  assign edge_ok = {1'b0, idx_q} < n_eff;
  assign stop    = ~busy[ButtonSlots];
  assign last    = cmd_q | (n_eff == '0) | ({1'b0, btn_q} == (n_eff - CountW'(1)));

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tlast_o  = last;
  assign m_axis_tdata_o  = {1'b0, timer_q, g_slot[btn_q], btn_q};

  assign lim = '{edge_step: edge_step_q, single_lim: single_lim_q,
                 double_lim: double_lim_q, vlong_lim: vlong_lim_q};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q         <= '0;
      tick_step_q   <= DelayW'(50);
      edge_step_q   <= DelayW'(10);
      single_lim_q  <= DelayW'(400);
      double_lim_q  <= DelayW'(600);
      vlong_lim_q   <= DelayW'(3000);
      active_high_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_NUM_BUTTONS: num_q         <= cfg_data_i[CountW-1:0];
        REG_TICK_STEP:   tick_step_q   <= cfg_data_i;
        REG_EDGE_STEP:   edge_step_q   <= cfg_data_i;
        REG_SINGLE_LIM:  single_lim_q  <= cfg_data_i;
        REG_DOUBLE_LIM:  double_lim_q  <= cfg_data_i;
        REG_VLONG_LIM:   vlong_lim_q   <= cfg_data_i;
        REG_ACTIVE_HIGH: active_high_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= s_axis_tdata_i[0];
      idx_q  <= s_axis_tdata_i[2:1];
      rel_q  <= s_axis_tdata_i[3];
      pins_q <= s_axis_tdata_i[7:4];
    end
  end

  always_comb begin
    state_d   = state_q;
    btn_d     = btn_q;
    timer_d   = timer_q;
    ctrl.op   = OP_IDLE;
    ctrl.step = cmd_q ? edge_step_q : tick_step_q;
    ctrl.rel  = rel_q;
    ctrl.stop = stop;
    for (int i = 0; i < ButtonSlots; i++) begin
      en[i] = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        ctrl.op = OP_CLEAR_G;
        en      = {ButtonSlots{in_acc}};
        if (in_acc) begin
          btn_d = s_axis_tdata_i[0] ? s_axis_tdata_i[2:1] : '0;
          if (s_axis_tdata_i[0]) begin
            state_d = ({1'b0, s_axis_tdata_i[2:1]} < n_eff) ? S_ADD : S_OUT;
          end else begin
            state_d = timer_q ? S_ADD : S_OUT;
          end
        end
      end
      S_ADD, S_CLASS: begin
        if (state_q == S_ADD) begin
          ctrl.op = OP_ADD;
          state_d = S_CLASS;
        end else begin
          ctrl.op = cmd_q ? OP_EDGE : OP_TICK;
          state_d = cmd_q ? S_OUT : S_STOP;
          if (cmd_q && edge_ok) timer_d = 1'b1;
        end
        for (int i = 0; i < ButtonSlots; i++) begin
          en[i] = cmd_q ? (idx_q == IdxW'(i)) : (CountW'(i) < n_eff);
        end
      end
      S_STOP: begin
        ctrl.op = OP_STOP;
        for (int i = 0; i < ButtonSlots; i++) begin
          en[i] = CountW'(i) < n_eff;
        end
        if (stop) timer_d = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          if (last) begin
            state_d = S_IDLE;
          end else begin
            btn_d = btn_q + IdxW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      timer_q <= 1'b0;
      btn_q   <= '0;
    end else begin
      state_q <= state_d;
      timer_q <= timer_d;
      btn_q   <= btn_d;
    end
  end

  assign busy[0] = 1'b0;

  for (genvar i = 0; i < ButtonSlots; i++) begin : g_slots
    if (i < NumCells) begin : g_cell
      bcgd_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .lim_i     (lim),
        .en_i      (en[i]),
        .pressed_i (pins_q[i] == active_high_q),
        .busy_i    (busy[i]),
        .busy_o    (busy[i+1]),
        .gesture_o (g_slot[i])
      );
    end else begin : g_empty
      assign busy[i+1] = busy[i];
      assign g_slot[i] = G_NONE;
    end
  end

endmodule

// ===== hdl/bcgd_cell.sv =====
module bcgd_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcgd_pkg::cell_ctrl_t ctrl_i,
  input  bcgd_pkg::lim_t      lim_i,
  input  logic                en_i,
  input  logic                pressed_i,
  input  logic                busy_i,
  output logic                busy_o,
  output bcgd_pkg::gesture_e  gesture_o
);
  import bcgd_pkg::*;

  logic [DelayW-1:0] delay_q, delay_d;
  logic [ClickW-1:0] click_q, click_d;
  gesture_e          rep_q, rep_d;
  gesture_e          g_q, g_d;
  logic [DelayW:0]   sum;
  logic [ClickW-1:0] click_inc;
  logic              in_window;

  assign sum       = {1'b0, delay_q} + {1'b0, ctrl_i.step};
  assign click_inc = click_q + ClickW'(1);
  assign in_window = (delay_q > lim_i.edge_step) && (delay_q < lim_i.double_lim);

  // Any button still holding or inside its click window keeps the timer alive
  assign busy_o    = busy_i | (en_i & ((rep_q != G_RELEASED) | in_window));
  assign gesture_o = g_q;

  always_comb begin
    gesture_e g;
    delay_d = delay_q;
    click_d = click_q;
    rep_d   = rep_q;
    g_d     = g_q;
    g       = G_NONE;
    if (en_i) begin
      case (ctrl_i.op)
        OP_CLEAR_G: g_d = G_NONE;
        OP_ADD: delay_d = sum[DelayW] ? DelayMax : sum[DelayW-1:0];
        OP_EDGE: begin
          if (ctrl_i.rel) begin
            if (delay_q > lim_i.single_lim) begin
              click_d = ClickReset;
              delay_d = '0;
              g       = G_RELEASED;
            end
          end else if (delay_q < lim_i.single_lim) begin
            click_d = click_inc;
            delay_d = '0;
            case (click_inc)
              8'd0: g = G_SINGLE;
              8'd1: g = G_DOUBLE;
              8'd2: begin
                g       = G_TRIPLE;
                click_d = ClickReset;
              end
              default: g = G_NONE;
            endcase
          end
          g_d = g;
          if (g != G_NONE) rep_d = g;
        end
        OP_TICK: begin
          if (pressed_i) begin
            if ((delay_q > lim_i.vlong_lim) && (click_q == '0)) begin
              g = G_VLONG;
            end else if (delay_q > lim_i.single_lim) begin
              case (click_q)
                8'd0:    g = G_LONG;
                8'd1:    g = G_DLONG;
                8'd2:    g = G_TLONG;
                default: g = G_NONE;
              endcase
            end
          end else if (delay_q >= lim_i.double_lim) begin
            click_d = ClickReset;
            g       = G_RELEASED;
          end
          g_d = g;
          if (g != G_NONE) rep_d = g;
        end
        OP_STOP: begin
          if (ctrl_i.stop) begin
            delay_d = '0;
            click_d = ClickReset;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      click_q <= ClickReset;
      rep_q   <= G_RELEASED;
      g_q     <= G_NONE;
    end else begin
      delay_q <= delay_d;
      click_q <= click_d;
      rep_q   <= rep_d;
      g_q     <= g_d;
    end
  end

endmodule

// ===== hdl/bcgd_checker.sv =====
module bcgd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);
  import bcgd_pkg::*;

  logic held_gesture;
  assign held_gesture = (m_axis_tdata_o[5:2] != G_NONE) && (m_axis_tdata_o[5:2] != G_RELEASED);

  // One item in flight: no new transaction while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken while results pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready right after an accepted item");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("result after the final one of an item");

  // A held or clicked gesture keeps the timer running
  a_timer_on_gesture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && held_gesture) |-> m_axis_tdata_o[6])
    else $error("gesture reported with timer stopped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind button_click_gesture_detector bcgd_checker u_bcgd_checker (.*);

// ===== tb/gesture_report_checker.sv =====
module gesture_report_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // [0] cmd, [2:1] button_index, [3] is_release, [7:4] pin_levels
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // [1:0] out_button, [5:2] gesture, [6] timer_running, [7] zero
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          reports_o,
  output logic [8:0]  seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bcgd_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0] button;
    gesture_e        gesture;
    logic            running;
    logic            closes;
  } gesture_report_t;

  gesture_report_t pending_reports [$];

  // register copies
  logic [CountW-1:0] buttons_cfg;
  logic [DelayW-1:0] tick_step;
  logic [DelayW-1:0] edge_step;
  logic [DelayW-1:0] single_lim;
  logic [DelayW-1:0] double_lim;
  logic [DelayW-1:0] vlong_lim;
  logic              press_level;

  // per-button gesture state
  logic [DelayW-1:0] hold_dly  [NumCells];
  logic [ClickW-1:0] clicks    [NumCells];
  gesture_e          shown     [NumCells];
  logic              timer_on;

  int         fails     = 0;
  int         pend      = 0;
  int         reports   = 0;
  logic [8:0] seen_mask = '0;

  assign fail_cnt_o = fails;
  assign pending_o  = pend;
  assign reports_o  = reports;
  assign seen_o     = seen_mask;

  function automatic logic [DelayW-1:0] sat_add(input logic [DelayW-1:0] a,
                                                input logic [DelayW-1:0] b);
    logic [DelayW:0] s;
    s = a + b;
    return s[DelayW] ? DelayMax : s[DelayW-1:0];
  endfunction

  task automatic predict_gestures(input logic [7:0] item);
    logic              is_edge;
    logic [IdxW-1:0]   btn;
    logic              rel;
    logic [3:0]        pins;
    int unsigned       n;
    int unsigned       i;
    gesture_e          gest [NumCells];
    logic              keep;
    logic [ClickW-1:0] c;
    gesture_report_t   want;
    is_edge = item[0];
    btn     = item[2:1];
    rel     = item[3];
    pins    = item[7:4];
    n       = (buttons_cfg > NumCells) ? NumCells : buttons_cfg;
    for (i = 0; i < NumCells; i++) gest[i] = G_NONE;

    if (is_edge) begin
      // edges on buttons out of use leave everything alone
      if (btn < n) begin
        hold_dly[btn] = sat_add(hold_dly[btn], edge_step);
        if (rel) begin
          if (hold_dly[btn] > single_lim) begin
            clicks[btn]   = ClickReset;
            hold_dly[btn] = '0;
            gest[0]       = G_RELEASED;
          end
        end else if (hold_dly[btn] < single_lim) begin
          clicks[btn] = clicks[btn] + 1'b1;
          case (clicks[btn])
            8'd0: gest[0] = G_SINGLE;
            8'd1: gest[0] = G_DOUBLE;
            8'd2: begin
              gest[0]     = G_TRIPLE;
              clicks[btn] = ClickReset;
            end
            default: ;
          endcase
          hold_dly[btn] = '0;
        end
        if (gest[0] != G_NONE) shown[btn] = gest[0];
        timer_on = 1'b1;
      end
      want.button  = btn;
      want.gesture = gest[0];
      want.running = timer_on;
      want.closes  = 1'b1;
      pending_reports.push_back(want);
    end else begin
      if (timer_on) begin
        for (i = 0; i < n; i++) begin
          hold_dly[i] = sat_add(hold_dly[i], tick_step);
          c = clicks[i];
          if (pins[i] == press_level) begin
            if (hold_dly[i] > vlong_lim && c == 8'd0) gest[i] = G_VLONG;
            else if (hold_dly[i] > single_lim) begin
              case (c)
                8'd0:    gest[i] = G_LONG;
                8'd1:    gest[i] = G_DLONG;
                8'd2:    gest[i] = G_TLONG;
                default: ;
              endcase
            end
          end else if (hold_dly[i] >= double_lim) begin
            clicks[i] = ClickReset;
            gest[i]   = G_RELEASED;
          end
          if (gest[i] != G_NONE) shown[i] = gest[i];
        end
        // keep running while any button is held or still inside its click window
        keep = 1'b0;
        for (i = 0; i < n; i++) begin
          if (shown[i] != G_RELEASED) keep = 1'b1;
          if (hold_dly[i] > edge_step && hold_dly[i] < double_lim) keep = 1'b1;
        end
        if (!keep) begin
          timer_on = 1'b0;
          for (i = 0; i < n; i++) begin
            hold_dly[i] = '0;
            clicks[i]   = ClickReset;
          end
        end
      end
      if (n == 0) begin
        want.button  = '0;
        want.gesture = G_NONE;
        want.running = timer_on;
        want.closes  = 1'b1;
        pending_reports.push_back(want);
      end else begin
        for (i = 0; i < n; i++) begin
          want.button  = i[IdxW-1:0];
          want.gesture = gest[i];
          want.running = timer_on;
          want.closes  = (i + 1 == n);
          pending_reports.push_back(want);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    gesture_report_t want;
    int unsigned     i;
    if (!rst_ni) begin
      buttons_cfg = '0;
      tick_step   = 16'd50;
      edge_step   = 16'd10;
      single_lim  = 16'd400;
      double_lim  = 16'd600;
      vlong_lim   = 16'd3000;
      press_level = 1'b0;
      for (i = 0; i < NumCells; i++) begin
        hold_dly[i] = '0;
        clicks[i]   = ClickReset;
        shown[i]    = G_RELEASED;
      end
      timer_on = 1'b0;
      pending_reports.delete();
      pend <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_NUM_BUTTONS: buttons_cfg = cfg_data_i[CountW-1:0];
          REG_TICK_STEP:   tick_step   = cfg_data_i;
          REG_EDGE_STEP:   edge_step   = cfg_data_i;
          REG_SINGLE_LIM:  single_lim  = cfg_data_i;
          REG_DOUBLE_LIM:  double_lim  = cfg_data_i;
          REG_VLONG_LIM:   vlong_lim   = cfg_data_i;
          REG_ACTIVE_HIGH: press_level = cfg_data_i[0];
          default: ;
        endcase
      end

      // compare before predicting: the oldest expectation belongs to an earlier transaction
      if (m_tvalid_i && m_tready_i) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report: button %0d gesture %0d", $time,
                   m_tdata_i[1:0], m_tdata_i[5:2]);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          if (m_tdata_i[1:0] !== want.button) begin
            $display("%0t: button mismatch: expected %0d, actual %0d", $time,
                     want.button, m_tdata_i[1:0]);
            fails++;
          end
          if (m_tdata_i[5:2] !== want.gesture) begin
            $display("%0t: gesture mismatch on button %0d: expected %0d, actual %0d", $time,
                     want.button, want.gesture, m_tdata_i[5:2]);
            fails++;
          end
          if (m_tdata_i[6] !== want.running) begin
            $display("%0t: timer flag mismatch on button %0d: expected %0b, actual %0b",
                     $time, want.button, want.running, m_tdata_i[6]);
            fails++;
          end
          if (m_tlast_i !== want.closes) begin
            $display("%0t: tlast mismatch on button %0d: expected %0b, actual %0b", $time,
                     want.button, want.closes, m_tlast_i);
            fails++;
          end
          if (m_tdata_i[7] !== 1'b0) begin
            $display("%0t: pad bit mismatch: expected 0, actual %0b", $time, m_tdata_i[7]);
            fails++;
          end
          reports++;
          seen_mask[want.gesture] = 1'b1;
        end
      end

      if (s_tvalid_i && s_tready_i) predict_gestures(s_tdata_i);
      pend <= pending_reports.size();
    end
  end

endmodule

// ===== tb/tb_button_click_gesture_detector.sv =====
module tb_button_click_gesture_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import bcgd_pkg::*;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 8;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic [7:0]  s_data    = '0;
  logic        sink_rdy  = 1'b0;
  logic        hold_off  = 1'b0;
  logic        cfg_valid = 1'b0;
  reg_idx_e    cfg_index = REG_NUM_BUTTONS;
  logic [15:0] cfg_data  = '0;

  wire         s_ready;
  wire         m_valid;
  wire         m_ready = sink_rdy & ~hold_off;
  wire  [7:0]  m_data;
  wire         m_last;
  wire         cfg_ready;

  int          fail_cnt;
  int          pending;
  int          reports;
  logic [8:0]  seen;

  bit          steady   = 1'b0;
  bit          hold_go  = 1'b0;
  logic [3:0]  held     = '0;
  int          items_sent = 0;
  int          settings   = 0;
  int          cycle_cnt  = 0;

  button_click_gesture_detector u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  gesture_report_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_valid),
    .s_tready_i  (s_ready),
    .s_tdata_i   (s_data),
    .m_tvalid_i  (m_valid),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_data),
    .m_tlast_i   (m_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .reports_o   (reports),
    .seen_o      (seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pack_item(input logic cmd, input logic [1:0] btn,
                                           input logic rel, input logic [3:0] pins);
    return {pins, rel, btn, cmd};
  endfunction

  task automatic send_item(input logic [7:0] item);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= item;
    do @(posedge clk); while (!s_ready);
    items_sent++;
  endtask

  task automatic send_tick(input logic [3:0] pins);
    send_item(pack_item(CMD_TICK, 2'd0, 1'b0, pins));
  endtask

  task automatic send_edge(input logic [1:0] btn, input logic rel);
    send_item(pack_item(CMD_EDGE, btn, rel, 4'h0));
  endtask

  // keep valid high across back-to-back writes; the caller drops it
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_registers(input logic [15:0] nb, input logic [15:0] tick,
                               input logic [15:0] edge_ms, input logic [15:0] single,
                               input logic [15:0] dbl, input logic [15:0] vlong,
                               input logic ah);
    write_reg(REG_NUM_BUTTONS, nb);
    write_reg(REG_TICK_STEP, tick);
    write_reg(REG_EDGE_STEP, edge_ms);
    write_reg(REG_SINGLE_LIM, single);
    write_reg(REG_DOUBLE_LIM, dbl);
    write_reg(REG_VLONG_LIM, vlong);
    write_reg(REG_ACTIVE_HIGH, {15'd0, ah});
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // limits a few ticks apart so holds reach long and very long quickly
  task automatic tuned_registers(input logic [15:0] nb, input logic ah);
    int unsigned step;
    int unsigned single;
    int unsigned edge_ms;
    int unsigned dbl;
    int unsigned vlong;
    step    = $urandom_range(20, 200);
    single  = step * $urandom_range(1, 4);
    edge_ms = $urandom_range(0, step);
    dbl     = single + step * $urandom_range(1, 3);
    vlong   = single + step * $urandom_range(1, 5);
    set_registers(nb, 16'(step), 16'(edge_ms), 16'(single), 16'(dbl), 16'(vlong), ah);
  endtask

  // drop valid, then wait until every report has drained and the block has settled
  task automatic wait_quiet();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // mostly press/release pairs with ticks that follow the held pins; some noise
  task automatic random_phase(input int count, input int unsigned nu, input logic ah);
    int unsigned r;
    logic [1:0]  b;
    logic        rel;
    logic [3:0]  pins;
    logic [3:0]  flip;
    int          k;
    int          j;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        for (j = 0; j < 4; j++) pins[j] = held[j] ? ah : ~ah;
        if ($urandom_range(0, 9) == 0) begin
          flip = 4'($urandom_range(1, 15));
          pins = pins ^ flip;
        end
        b   = 2'($urandom_range(0, 3));
        rel = 1'($urandom_range(0, 1));
        send_item(pack_item(CMD_TICK, b, rel, pins));
      end else if (r < 92 && nu > 0) begin
        b    = 2'($urandom_range(0, nu - 1));
        pins = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 6) == 0) begin
          // repeat the last edge kind: a broken press/release sequence
          rel = ~held[b];
        end else begin
          rel     = held[b];
          held[b] = ~held[b];
        end
        send_item(pack_item(CMD_EDGE, b, rel, pins));
      end else begin
        b    = 2'($urandom_range(0, 3));
        rel  = 1'($urandom_range(0, 1));
        pins = 4'($urandom_range(0, 15));
        send_item(pack_item(CMD_EDGE, b, rel, pins));
      end
    end
  endtask

  initial begin : sink
    int run;
    int stall;
    forever begin
      if (steady) begin
        run   = 16;
        stall = 0;
      end else begin
        run   = $urandom_range(1, 8);
        stall = pick_gap();
      end
      sink_rdy <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        sink_rdy <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // one long receiver stall while the sender keeps pushing
  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: cycle limit of %0d reached", $time, CycleLimit);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic ah;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short limits: clicks, long holds and the stop within a few ticks
    set_registers(16'd2, 16'd100, 16'd10, 16'd150, 16'd250, 16'd400, 1'b0);
    send_tick(4'hF);                  // timer still stopped
    send_edge(2'd3, 1'b0);            // button out of use
    send_edge(2'd0, 1'b0);            // single
    send_edge(2'd0, 1'b1);            // quick release, no gesture
    send_edge(2'd0, 1'b0);            // double
    send_edge(2'd0, 1'b0);            // triple
    send_edge(2'd1, 1'b0);
    repeat (5) send_tick(4'b1101);    // button 1 held: long, then very long
    send_edge(2'd1, 1'b1);            // release after a long hold
    repeat (3) send_tick(4'hF);       // click window runs out, timer stops
    send_edge(2'd0, 1'b0);
    send_edge(2'd0, 1'b0);
    repeat (2) send_tick(4'b1110);    // double long
    send_edge(2'd0, 1'b1);
    wait_quiet();

    // saturate every hold delay counter
    set_registers(16'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_edge(2'd2, 1'b0);
    send_tick(4'b0100);
    send_edge(2'd1, 1'b0);
    wait_quiet();

    // no buttons in use while the timer runs
    set_registers(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_tick(4'hF);
    send_edge(2'd0, 1'b0);
    wait_quiet();

    held = '0;
    tuned_registers(16'd4, 1'b0);
    random_phase(15, 4, 1'b0);
    wait_quiet();

    tuned_registers(16'd3, 1'b1);
    random_phase(5, 3, 1'b1);
    steady  = 1'b1;
    hold_go = 1'b1;
    random_phase(12, 3, 1'b1);
    steady  = 1'b0;
    random_phase(8, 3, 1'b1);
    wait_quiet();

    set_registers(16'd4, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    random_phase(10, 4, 1'b0);
    wait_quiet();

    ah = 1'($urandom_range(0, 1));
    set_registers(16'd4, 16'hFFFF, 16'hFFFF, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), ah);
    random_phase(15, 4, ah);
    wait_quiet();

    // count above the button slots
    ah = 1'($urandom_range(0, 1));
    tuned_registers(16'd7, ah);
    random_phase(15, 4, ah);
    wait_quiet();

    steady = 1'b1;
    tuned_registers(16'd1, 1'b0);
    random_phase(14, 1, 1'b0);
    wait_quiet();
    steady = 1'b0;

    $display("covered %0d items under %0d register settings, %0d reports checked",
             items_sent, settings, reports);
    $display("gesture codes reported, one bit per code from none up: %b", seen);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
